// File: hw/rtl/vgm_command_stripper_defines.svh
// ----------------------------------------------------------------------------
// VGM command stripper assertion macros
// Shared property templates for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VGM_COMMAND_STRIPPER_DEFINES_SVH
`define VGM_COMMAND_STRIPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VGMCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("vgm_command_stripper: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VGMCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("vgm_command_stripper: next-cycle check failed");

`endif

// File: hw/rtl/vgmcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM command stripper package
// Shared constants, codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package vgmcs_pkg;

	localparam int POSITION_BITS_DEFAULT = 24;
	localparam int FIELD_POS_W = 24;
	localparam int OFFSET_W = 24;

	// Command bytes.
	localparam logic [7:0] CMD_COPY2 = 8'hb9;
	localparam logic [7:0] CMD_WAIT  = 8'h61;
	localparam logic [7:0] CMD_FRAME = 8'h62;
	localparam logic [7:0] CMD_END   = 8'h66;

	// Replay bytes.
	localparam logic [7:0] BYTE_MAX_WAIT   = 8'hef;
	localparam logic [7:0] BYTE_ONE_FRAME  = 8'hf0;
	localparam logic [7:0] BYTE_SHORT_WAIT = 8'he0;
	localparam logic [7:0] BYTE_END        = 8'hff;

	// Item kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Samples per frame and the frame group size of a long wait.
	localparam int FRAME_SAMPLES = 735;
	localparam int FRAMES_PER_MAX = 17;
	localparam int FRAMES_W = 7;
	// Reciprocal of the frame length; exact for every 16-bit sample count.
	localparam int RECIP_SHIFT = 26;
	localparam int RECIP_MULT = ((1 << RECIP_SHIFT) + FRAME_SAMPLES - 1) / FRAME_SAMPLES;
	localparam int PROD_W = 33;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_COPY,
		EMIT_F0,
		EMIT_END,
		EMIT_ERR,
		EMIT_EF,
		EMIT_E
	} emit_sel_t;

	typedef struct packed {
		logic      accept;
		logic      clear;
		logic      count_in;
		logic      latch_check;
		logic      store_low;
		logic      load_frames;
		logic      sub17;
		logic      last;
		emit_sel_t emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic start;
		logic is_copy;
		logic is_wait;
		logic is_frame;
		logic is_end;
		logic out_free;
		logic frames_ge17;
		logic frames_eq17;
		logic frames_zero;
		logic frames_one;
	} dp_status_t;

endpackage

// File: hw/rtl/vgmcs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM byte stream channel
// Valid/ready channel carrying one input byte and its stream start flag.
// ----------------------------------------------------------------------------
interface vgmcs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_start;

	modport source (output valid, output data_byte, output stream_start, input ready);
	modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

// File: hw/rtl/vgmcs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay stream channel
// Valid/ready channel carrying one replay result item.
// ----------------------------------------------------------------------------
interface vgmcs_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [1:0]  item_kind;
	logic [23:0] out_position;
	logic [23:0] loop_position;
	logic        last_of_run;

	modport source (output valid, output out_byte, output item_kind, output out_position,
		output loop_position, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input item_kind, input out_position,
		input loop_position, input last_of_run, output ready);
endinterface

// File: hw/rtl/vgm_command_stripper.sv
`timescale 1ns / 1ps
// A result is registered on the output in the cycle after its byte is accepted; the
// results of a wait command come from the frame count loaded with its high byte.
// The input takes one byte per cycle while the output drains and no wait command is
// emitting; a wait command holds the input while it emits its results, or if it has none.
// Reset: arst_n clears the parse state, position counters, loop latch and offset register.
// ----------------------------------------------------------------------------
// VGM command stripper
// Turns a VGM command byte stream into a compact replay stream.
// ----------------------------------------------------------------------------
`include "vgm_command_stripper_defines.svh"

module vgm_command_stripper
	import vgmcs_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [OFFSET_W-1:0] cfg_wr_data,
	vgmcs_in_if.sink            byte_stream,
	vgmcs_out_if.source         replay
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	vgmcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.in_ready (byte_stream.ready),
		.cmd      (cmd)
	);

	vgmcs_dpath #(
		.POSITION_BITS (POSITION_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (byte_stream.valid),
		.data_byte     (byte_stream.data_byte),
		.stream_start  (byte_stream.stream_start),
		.out_ready     (replay.ready),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (replay.valid),
		.out_byte      (replay.out_byte),
		.item_kind     (replay.item_kind),
		.out_position  (replay.out_position),
		.loop_position (replay.loop_position),
		.last_of_run   (replay.last_of_run)
	);

	// Input is taken only when the output register can hold a new result.
	`VGMCS_ASSERT_NOW(a_ready_needs_room, clk, arst_n, byte_stream.ready, !replay.valid || replay.ready)
	// The controller never overwrites a result that is still waiting.
	`VGMCS_ASSERT_NOW(a_emit_needs_room, clk, arst_n, cmd.emit != EMIT_NONE, status.out_free)
	// Every emitted result shows up on the output in the next cycle.
	`VGMCS_ASSERT_NEXT(a_emit_shows, clk, arst_n, cmd.emit != EMIT_NONE, replay.valid)
	// Frame subtraction runs only while the input is held off.
	`VGMCS_ASSERT_NOW(a_sub_no_accept, clk, arst_n, cmd.sub17, !cmd.accept)

endmodule

// File: hw/rtl/vgmcs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM command stripper datapath
// Counters, loop latch, wait frame arithmetic and the output register.
// ----------------------------------------------------------------------------
module vgmcs_dpath
	import vgmcs_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [OFFSET_W-1:0]    cfg_wr_data,
	input  logic                   in_valid,
	input  logic [7:0]             data_byte,
	input  logic                   stream_start,
	input  logic                   out_ready,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status,
	output logic                   out_valid,
	output logic [7:0]             out_byte,
	output logic [1:0]             item_kind,
	output logic [FIELD_POS_W-1:0] out_position,
	output logic [FIELD_POS_W-1:0] loop_position,
	output logic                   last_of_run
);

	logic [OFFSET_W-1:0]      offset_q;
	logic [POSITION_BITS-1:0] in_cnt_q;
	logic [POSITION_BITS-1:0] out_cnt_q;
	logic [POSITION_BITS-1:0] loop_q;
	logic [7:0]               low_q;
	logic [FRAMES_W-1:0]      frames_q;
	logic                     out_valid_q;
	logic [7:0]               out_byte_q;
	logic [1:0]               item_kind_q;
	logic [FIELD_POS_W-1:0]   out_position_q;
	logic [FIELD_POS_W-1:0]   loop_position_q;
	logic                     last_q;

	logic [POSITION_BITS-1:0] in_cnt_base;
	logic [POSITION_BITS-1:0] out_cnt_base;
	logic [POSITION_BITS-1:0] loop_cur;
	logic [POSITION_BITS-1:0] loop_next;
	logic                     latch_hit;
	logic                     takes_pos;
	logic [PROD_W-1:0]        product;
	logic [FRAMES_W-1:0]      frames_new;
	logic [7:0]               emit_byte;
	logic [1:0]               emit_kind;

	// A stream start clears the counters before its byte is processed.
	assign in_cnt_base  = cmd.clear ? '0 : in_cnt_q;
	assign out_cnt_base = cmd.clear ? '0 : out_cnt_q;
	assign loop_cur     = cmd.clear ? '0 : loop_q;
	assign latch_hit    = cmd.latch_check && (in_cnt_base == POSITION_BITS'(offset_q));
	assign loop_next    = latch_hit ? out_cnt_base : loop_cur;
	assign takes_pos    = (cmd.emit != EMIT_NONE) && (cmd.emit != EMIT_ERR);

	assign product    = PROD_W'({data_byte, low_q}) * PROD_W'(RECIP_MULT);
	assign frames_new = product[RECIP_SHIFT +: FRAMES_W];

	always_comb begin
		emit_byte = data_byte;
		emit_kind = KIND_DATA;
		unique case (cmd.emit)
			EMIT_NONE: begin
				emit_byte = data_byte;
			end
			EMIT_COPY: begin
				emit_byte = data_byte;
			end
			EMIT_F0: begin
				emit_byte = BYTE_ONE_FRAME;
			end
			EMIT_END: begin
				emit_byte = BYTE_END;
				emit_kind = KIND_END;
			end
			EMIT_ERR: begin
				emit_byte = data_byte;
				emit_kind = KIND_ERROR;
			end
			EMIT_EF: begin
				emit_byte = BYTE_MAX_WAIT;
			end
			EMIT_E: begin
				emit_byte = BYTE_SHORT_WAIT + 8'(frames_q) - 8'd2;
			end
			default: begin
				emit_byte = data_byte;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			loop_q      <= '0;
			low_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				offset_q <= cfg_wr_data;
			end
			in_cnt_q  <= in_cnt_base + POSITION_BITS'(cmd.count_in);
			out_cnt_q <= out_cnt_base + POSITION_BITS'(takes_pos);
			loop_q    <= loop_next;
			if (cmd.clear) begin
				low_q <= '0;
			end
			if (cmd.store_low) begin
				low_q <= data_byte;
			end
			if (cmd.emit != EMIT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_frames) begin
			frames_q <= frames_new;
		end else if (cmd.sub17) begin
			frames_q <= frames_q - FRAMES_W'(FRAMES_PER_MAX);
		end
		if (cmd.emit != EMIT_NONE) begin
			out_byte_q      <= emit_byte;
			item_kind_q     <= emit_kind;
			out_position_q  <= FIELD_POS_W'(out_cnt_base);
			loop_position_q <= FIELD_POS_W'(loop_next);
			last_q          <= cmd.last;
		end
	end

	assign status.in_valid    = in_valid;
	assign status.start       = stream_start;
	assign status.is_copy     = (data_byte == CMD_COPY2);
	assign status.is_wait     = (data_byte == CMD_WAIT);
	assign status.is_frame    = (data_byte == CMD_FRAME);
	assign status.is_end      = (data_byte == CMD_END);
	assign status.out_free    = !out_valid_q || out_ready;
	assign status.frames_ge17 = (frames_q >= FRAMES_W'(FRAMES_PER_MAX));
	assign status.frames_eq17 = (frames_q == FRAMES_W'(FRAMES_PER_MAX));
	assign status.frames_zero = (frames_q == '0);
	assign status.frames_one  = (frames_q == FRAMES_W'(1));

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign item_kind     = item_kind_q;
	assign out_position  = out_position_q;
	assign loop_position = loop_position_q;
	assign last_of_run   = last_q;

endmodule

// File: hw/rtl/vgmcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM command stripper controller
// Parse state machine that steers the datapath one byte or result at a time.
// ----------------------------------------------------------------------------
module vgmcs_ctrl
	import vgmcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t status,
	output logic       in_ready,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		PH_CMD,
		PH_COPY1,
		PH_COPY2,
		PH_WAIT_LO,
		PH_WAIT_HI,
		PH_WAIT_EMIT,
		PH_STOPPED
	} phase_t;

	phase_t state_q;
	phase_t phase;
	phase_t state_next;
	logic   accept;

	assign in_ready = (state_q != PH_WAIT_EMIT) && status.out_free;
	assign accept   = in_ready && status.in_valid;
	// A stream start byte is always a command byte.
	assign phase    = status.start ? PH_CMD : state_q;

	always_comb begin
		cmd            = '0;
		cmd.emit       = EMIT_NONE;
		state_next     = state_q;
		if (accept) begin
			cmd.accept   = 1'b1;
			cmd.clear    = status.start;
			cmd.count_in = (phase != PH_STOPPED);
			state_next   = phase;
			unique case (phase)
				PH_CMD: begin
					cmd.latch_check = 1'b1;
					priority if (status.is_copy) begin
						state_next = PH_COPY1;
					end else if (status.is_wait) begin
						state_next = PH_WAIT_LO;
					end else if (status.is_frame) begin
						cmd.emit = EMIT_F0;
						cmd.last = 1'b1;
					end else if (status.is_end) begin
						cmd.emit   = EMIT_END;
						cmd.last   = 1'b1;
						state_next = PH_STOPPED;
					end else begin
						cmd.emit   = EMIT_ERR;
						cmd.last   = 1'b1;
						state_next = PH_STOPPED;
					end
				end
				PH_COPY1: begin
					cmd.emit   = EMIT_COPY;
					cmd.last   = 1'b1;
					state_next = PH_COPY2;
				end
				PH_COPY2: begin
					cmd.emit   = EMIT_COPY;
					cmd.last   = 1'b1;
					state_next = PH_CMD;
				end
				PH_WAIT_LO: begin
					cmd.store_low = 1'b1;
					state_next    = PH_WAIT_HI;
				end
				PH_WAIT_HI: begin
					cmd.load_frames = 1'b1;
					state_next      = PH_WAIT_EMIT;
				end
				PH_STOPPED: begin
					state_next = PH_STOPPED;
				end
				default: begin
					state_next = PH_CMD;
				end
			endcase
		end else if (state_q == PH_WAIT_EMIT) begin
			// One wait result per cycle while the output register is free.
			priority if (status.frames_zero) begin
				state_next = PH_CMD;
			end else if (!status.out_free) begin
				state_next = PH_WAIT_EMIT;
			end else if (status.frames_ge17) begin
				cmd.emit  = EMIT_EF;
				cmd.sub17 = 1'b1;
				cmd.last  = status.frames_eq17;
				if (status.frames_eq17) begin
					state_next = PH_CMD;
				end
			end else if (status.frames_one) begin
				cmd.emit   = EMIT_F0;
				cmd.last   = 1'b1;
				state_next = PH_CMD;
			end else begin
				cmd.emit   = EMIT_E;
				cmd.last   = 1'b1;
				state_next = PH_CMD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_CMD;
		end else begin
			state_q <= state_next;
		end
	end

endmodule
